@@ hdl/bsad_pkg.sv @@
// Shared types and constants of the bank switched address decoder.
// Depends on nothing; bsad_io_decode and the top level import it.
`default_nettype none

package bsad_pkg;

	// Bus access kinds.
	localparam logic [1:0] KIND_MEM_RD = 2'd0;
	localparam logic [1:0] KIND_MEM_WR = 2'd1;
	localparam logic [1:0] KIND_IO_RD  = 2'd2;
	localparam logic [1:0] KIND_IO_WR  = 2'd3;

	// Target codes.
	localparam logic [2:0] TGT_LOWROM  = 3'd0;
	localparam logic [2:0] TGT_CHARROM = 3'd1;
	localparam logic [2:0] TGT_DRAM    = 3'd2;
	localparam logic [2:0] TGT_VRAM    = 3'd3;
	localparam logic [2:0] TGT_HIGHROM = 3'd4;
	localparam logic [2:0] TGT_IO      = 3'd5;

	// I/O device codes.
	localparam logic [3:0] DEV_SERIAL  = 4'd0;
	localparam logic [3:0] DEV_CRT     = 4'd1;
	localparam logic [3:0] DEV_PPI     = 4'd2;
	localparam logic [3:0] DEV_CTC     = 4'd3;
	localparam logic [3:0] DEV_FDC     = 4'd4;
	localparam logic [3:0] DEV_BANK    = 4'd5;
	localparam logic [3:0] DEV_JOY     = 4'd6;
	localparam logic [3:0] DEV_PALETTE = 4'd7;
	localparam logic [3:0] DEV_PSG     = 4'd8;
	localparam logic [3:0] DEV_QDC     = 4'd9;
	localparam logic [3:0] DEV_PIO     = 4'd10;
	localparam logic [3:0] DEV_NONE    = 4'd11;

	// I/O port bases.
	localparam logic [7:0] PORT_SERIAL    = 8'hB0;
	localparam logic [7:0] PORT_CRT       = 8'hCC;
	localparam logic [7:0] PORT_PPI       = 8'hD0;
	localparam logic [7:0] PORT_CTC       = 8'hD4;
	localparam logic [7:0] PORT_FDC       = 8'hD8;
	localparam logic [7:0] PORT_FDC_LAST  = 8'hDF;
	localparam logic [7:0] PORT_BANK_LAST = 8'hE6;
	localparam logic [7:0] PORT_JOY       = 8'hF0;
	localparam logic [7:0] PORT_JOY_LAST  = 8'hF1;
	localparam logic [7:0] PORT_PSG       = 8'hF2;
	localparam logic [7:0] PORT_QDC       = 8'hF4;
	localparam logic [7:0] PORT_PIO       = 8'hFC;

	// Bank switching ports.
	localparam logic [7:0] PORT_BANK_0 = 8'hE0;
	localparam logic [7:0] PORT_BANK_1 = 8'hE1;
	localparam logic [7:0] PORT_BANK_2 = 8'hE2;
	localparam logic [7:0] PORT_BANK_3 = 8'hE3;
	localparam logic [7:0] PORT_BANK_4 = 8'hE4;

	// Memory map boundaries.
	localparam logic [15:0] ADDR_VRAM_MASK = 16'hC000;
	localparam logic [15:0] ADDR_VRAM      = 16'h8000;
	localparam logic [15:0] ADDR_HIGHROM   = 16'hE000;

	// Result of decoding one I/O port.
	typedef struct packed {
		logic [3:0] dev;
		logic [7:0] offset;
	} io_dec_t;

	// Bank flags.
	typedef struct packed {
		logic low_is_dram;
		logic char_is_dram;
		logic video_mapped;
		logic high_is_dram;
	} bank_t;

	localparam bank_t BANK_RESET = '{low_is_dram: 1'b0, char_is_dram: 1'b0,
		video_mapped: 1'b1, high_is_dram: 1'b0};

endpackage

`default_nettype wire

@@ hdl/bsad_req_if.sv @@
// Valid/ready channel that carries one CPU bus access.
// Depends on nothing but the language.
`default_nettype none

interface bsad_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink   (input valid, input kind, input address, output ready);
endinterface

`default_nettype wire

@@ hdl/bsad_res_if.sv @@
// Valid/ready channel that carries one decoded access.
// Depends on nothing but the language.
`default_nettype none

interface bsad_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target;
	logic [15:0] local_address;
	logic        write_blocked;
	logic [3:0]  io_device;

	modport source (output valid, output target, output local_address,
		output write_blocked, output io_device, input ready);
	modport sink   (input valid, input target, input local_address,
		input write_blocked, input io_device, output ready);
endinterface

`default_nettype wire

@@ hdl/bsad_io_decode.sv @@
// I/O port decoder: maps the low address byte to a device and a port offset.
// Depends on bsad_pkg.
`default_nettype none

module bsad_io_decode (
	input  wire logic            is_write,
	input  wire logic [7:0]      port,
	output bsad_pkg::io_dec_t    dec
);
	import bsad_pkg::*;

	logic [3:0] dev;
	logic [7:0] base;

	// Priority order matters: the joystick and palette share a port.
	always_comb begin
		dev  = DEV_NONE;
		base = 8'h00;
		if (port >= PORT_SERIAL && port <= PORT_SERIAL + 8'd3) begin
			dev  = DEV_SERIAL;
			base = PORT_SERIAL;
		end else if (port >= PORT_CRT && port <= PORT_CRT + 8'd3) begin
			dev  = DEV_CRT;
			base = PORT_CRT;
		end else if (port >= PORT_PPI && port <= PORT_PPI + 8'd3) begin
			dev  = DEV_PPI;
			base = PORT_PPI;
		end else if (port >= PORT_CTC && port <= PORT_CTC + 8'd3) begin
			dev  = DEV_CTC;
			base = PORT_CTC;
		end else if (port >= PORT_FDC && port <= PORT_FDC_LAST) begin
			dev  = DEV_FDC;
			base = PORT_FDC;
		end else if (port >= PORT_BANK_0 && port <= PORT_BANK_LAST) begin
			dev  = DEV_BANK;
			base = PORT_BANK_0;
		end else if (!is_write && (port == PORT_JOY || port == PORT_JOY_LAST)) begin
			dev  = DEV_JOY;
			base = PORT_JOY;
		end else if (is_write && port == PORT_JOY) begin
			dev  = DEV_PALETTE;
			base = PORT_JOY;
		end else if (port == PORT_PSG) begin
			dev  = DEV_PSG;
			base = PORT_PSG;
		end else if (port >= PORT_QDC && port <= PORT_QDC + 8'd3) begin
			dev  = DEV_QDC;
			base = PORT_QDC;
		end else if (port >= PORT_PIO) begin
			dev  = DEV_PIO;
			base = PORT_PIO;
		end
	end

	// An unmapped port has a base of zero, so its offset is the port itself.
	assign dec.dev    = dev;
	assign dec.offset = port - base;

endmodule

`default_nettype wire

@@ hdl/bank_switched_address_decoder.sv @@
// Top level of the bank switched address decoder: bank flags, memory decode
// and the result register with its skid stage. Depends on bsad_pkg,
// bsad_req_if, bsad_res_if and bsad_io_decode.
`default_nettype none

// The decoder takes one CPU bus access per clock on req while req.ready is
// high and registers each decoded access for res, parking it in the
// skid register while res stalls. A memory access is steered to
// low ROM, character ROM, DRAM, video RAM or high ROM according to four bank
// flags; a write that lands on any ROM, the character ROM included, is
// flagged as blocked. An I/O access is decoded on the low address byte to a
// device code and an offset from the device's base port, and ports 0xE0 to
// 0xE4 switch the bank flags at the edge where the transfer is taken, so the
// very next access already sees the new mapping. After reset the low ROM,
// character ROM, video RAM and high ROM are all mapped in. The result
// register is backed by a one-entry skid register, so req stays ready while a
// finished result waits on res; req only stalls once both hold a result.
module bank_switched_address_decoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsad_req_if.sink   req,
	bsad_res_if.source res
);
	import bsad_pkg::*;

	typedef struct packed {
		logic [2:0]  target;
		logic [15:0] local_address;
		logic        write_blocked;
		logic [3:0]  io_device;
	} res_t;

	bank_t   bank_q;
	res_t    out_q;
	res_t    skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	res_t    res_d;
	io_dec_t io_dec;
	logic    in_xfer;
	logic    out_xfer;
	logic    is_io;
	logic    is_write;
	logic [7:0] port;

	assign is_io    = req.kind[1];
	assign is_write = req.kind[0];
	assign port     = req.address[7:0];

	// Ready only depends on the skid register, never on res.ready.
	assign req.ready = !skid_valid_q;
	assign in_xfer   = req.valid && req.ready;
	assign out_xfer  = out_valid_q && res.ready;

	bsad_io_decode u_io_decode (
		.is_write (is_write),
		.port     (port),
		.dec      (io_dec)
	);

	// Decode of the current access against the bank flags as they stand
	// before this transfer.
	always_comb begin
		res_d.target        = TGT_DRAM;
		res_d.local_address = req.address;
		res_d.write_blocked = 1'b0;
		res_d.io_device     = DEV_NONE;
		if (is_io) begin
			res_d.target        = TGT_IO;
			res_d.local_address = {8'h00, io_dec.offset};
			res_d.io_device     = io_dec.dev;
		end else begin
			if (req.address[15:12] == 4'h0) begin
				if (!bank_q.low_is_dram) begin
					res_d.target = TGT_LOWROM;
				end
			end else if (req.address[15:12] == 4'h1) begin
				if (!bank_q.char_is_dram) begin
					res_d.target        = TGT_CHARROM;
					res_d.local_address = {4'h0, req.address[11:0]};
				end
			end else if ((req.address & ADDR_VRAM_MASK) == ADDR_VRAM) begin
				if (bank_q.video_mapped) begin
					res_d.target        = TGT_VRAM;
					res_d.local_address = {2'b00, req.address[13:0]};
				end
			end else if (req.address >= ADDR_HIGHROM) begin
				if (!bank_q.high_is_dram) begin
					res_d.target        = TGT_HIGHROM;
					res_d.local_address = {3'b000, req.address[12:0]};
				end
			end
			// All ROMs are read-only, the character ROM too.
			res_d.write_blocked = is_write && (res_d.target == TGT_LOWROM ||
				res_d.target == TGT_CHARROM || res_d.target == TGT_HIGHROM);
		end
	end

	// Bank switching. Reads and writes of the same port act differently;
	// the prohibit and return ports change nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= BANK_RESET;
		end else if (in_xfer && is_io) begin
			if (!is_write) begin
				unique case (port)
					PORT_BANK_0: begin
						bank_q.char_is_dram <= 1'b0;
						bank_q.video_mapped <= 1'b1;
					end
					PORT_BANK_1: begin
						bank_q.char_is_dram <= 1'b1;
						bank_q.video_mapped <= 1'b0;
					end
					default: begin
					end
				endcase
			end else begin
				unique case (port)
					PORT_BANK_0: begin
						bank_q.low_is_dram  <= 1'b1;
						bank_q.char_is_dram <= 1'b1;
					end
					PORT_BANK_1: bank_q.high_is_dram <= 1'b1;
					PORT_BANK_2: bank_q.low_is_dram  <= 1'b0;
					PORT_BANK_3: bank_q.high_is_dram <= 1'b0;
					PORT_BANK_4: bank_q <= BANK_RESET;
					default: begin
					end
				endcase
			end
		end
	end

	// Result register and skid register. A result parked in the skid
	// register always moves to the result register before new ones arrive,
	// which keeps the order of results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_q <= skid_q;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.target        = out_q.target;
	assign res.local_address = out_q.local_address;
	assign res.write_blocked = out_q.write_blocked;
	assign res.io_device     = out_q.io_device;

`ifndef NO_ASSERTIONS
	// The skid register is only filled behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the result register is empty");

	// Bank flags move only on an I/O transfer.
	a_bank_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_xfer && is_io) |=> $stable(bank_q))
		else $error("bank flags changed without an I/O transfer");

	// A write to the all-ROM port restores the start-up mapping.
	a_bank_restore: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req.kind == KIND_IO_WR && port == PORT_BANK_4)
		|=> bank_q == BANK_RESET)
		else $error("all-ROM port did not restore the start-up mapping");

	// Only a ROM target can block a write.
	a_blocked_rom: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.write_blocked) |-> (res.target == TGT_LOWROM ||
		res.target == TGT_CHARROM || res.target == TGT_HIGHROM))
		else $error("write blocked on a target that is not a ROM");

	// Memory results carry no device.
	a_mem_no_dev: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.target != TGT_IO) |-> res.io_device == DEV_NONE)
		else $error("memory result carries an I/O device code");
`endif

endmodule

`default_nettype wire
